// ===== rtl/srsw_pkg.sv =====
package srsw_pkg;

   // Input kinds carried on req_tuser. Kind three behaves as a plain step.
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STEP  = 2'd1;
   localparam logic [1:0] FUNC_ACK   = 2'd2;

   // Register indexes on the CSR write channel.
   localparam logic [1:0] REG_TOTAL   = 2'd0;
   localparam logic [1:0] REG_SPAN    = 2'd1;
   localparam logic [1:0] REG_TIMEOUT = 2'd2;

   localparam logic [7:0] TOTAL_RST   = 8'd1;
   localparam logic [3:0] SPAN_RST    = 4'd10;
   localparam logic [3:0] TIMEOUT_RST = 4'd3;
   localparam logic [3:0] WAIT_MAX    = 4'd15;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_NEW,
      ST_AGE_RD,
      ST_AGE_EV,
      ST_ACK_RD,
      ST_ACK_WR,
      ST_SLIDE_RD,
      ST_SLIDE_EV,
      ST_DONE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic clear_start;
      logic clear_wr;
      logic step_start;
      logic emit_new;
      logic age_init;
      logic age_rd;
      logic age_wr;
      logic ack_rd;
      logic ack_wr;
      logic slide_rd;
      logic slide_wr;
      logic done_chk;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic clear_end;
      logic in_range;
      logic new_ok;
      logic age_end;
      logic ack_ok;
      logic slide_go;
      logic fin_now;
      logic finished;
      logic push_block;
   } stat_type;

endpackage

// ===== rtl/selective_repeat_sender_window_unit.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser[1:0] func, tdata[7:0] ack_seq
// rsp       out        rsp_tvalid/rsp_tready  tdata[7:0] send_seq, [8] is_resend,
//                                             [9] transfer_done, tlast last
// csr       in         csr_valid/csr_ready    csr_index register, csr_wdata value
//
// A step ages each window entry from the base in turn (up to 16 entries). An acknowledge
// is dropped if stray, else it marks its entry and slides the base over marked entries;
// the single-port state memory gives each entry a read state and a write state.
// A start transaction and reset both run a clearing pass over all MAX_PACKETS words with
// req_tready low; CSR writes are taken at any time.
// A stalled result register holds the state machine only when another result is ready.
module selective_repeat_sender_window_unit
   import srsw_pkg::*;
#(
   parameter int MAX_PACKETS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ack_seq
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] send_seq, [8] is_resend, [9] transfer_done
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   srsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srsw_dpath #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ack_seq    (req_tdata),
      .csr_wr     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/srsw_ctrl.sv =====
module srsw_ctrl
   import srsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_func,
   output logic       req_tready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] func_ff, func_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         func_ff  <= FUNC_STEP;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == FUNC_START) begin
                  cmd.clear_start = 1'b1;
                  state_in        = ST_CLEAR;
               end else if (!stat.finished) begin
                  cmd.step_start = 1'b1;
                  func_in        = req_func;
                  state_in       = ST_NEW;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_NEW: begin
            if (!stat.push_block) begin
               cmd.emit_new = stat.in_range && stat.new_ok;
               if (stat.in_range && func_ff != FUNC_ACK) begin
                  cmd.age_init = 1'b1;
                  state_in     = ST_AGE_RD;
               end else if (func_ff == FUNC_ACK) begin
                  state_in = ST_ACK_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_AGE_RD: begin
            cmd.age_rd = 1'b1;
            state_in   = ST_AGE_EV;
         end
         ST_AGE_EV: begin
            if (!stat.push_block) begin
               cmd.age_wr = 1'b1;
               state_in   = stat.age_end ? ST_DONE : ST_AGE_RD;
            end
         end
         ST_ACK_RD: begin
            if (stat.ack_ok) begin
               cmd.ack_rd = 1'b1;
               state_in   = ST_ACK_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACK_WR: begin
            cmd.ack_wr = 1'b1;
            state_in   = ST_SLIDE_RD;
         end
         ST_SLIDE_RD: begin
            if (stat.in_range) begin
               cmd.slide_rd = 1'b1;
               state_in     = ST_SLIDE_EV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SLIDE_EV: begin
            if (stat.slide_go) begin
               cmd.slide_wr = 1'b1;
               state_in     = ST_SLIDE_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.push_block) begin
               cmd.done_chk = 1'b1;
               state_in     = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stat.push_block) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/srsw_dpath.sv =====
module srsw_dpath
   import srsw_pkg::*;
#(
   parameter int MAX_PACKETS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  ack_seq,
   input  logic        csr_wr,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = $clog2(MAX_PACKETS);

   logic [AW-1:0] slot_tab [256];

   // Sequence number to memory slot; every entry is a constant.
   for (genvar k = 0; k < 256; k++) begin : g_slot
      assign slot_tab[k] = AW'(k % MAX_PACKETS);
   end

   // Each word holds the acknowledge mark in bit 4 and the wait count below.
   logic [4:0]    mem [MAX_PACKETS];
   logic [4:0]    rd_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [4:0]    mem_wdata;
   logic [7:0]    seq_sel;

   logic [7:0]    total_ff, total_in;
   logic [3:0]    span_ff, span_in;
   logic [3:0]    tmo_ff, tmo_in;
   logic [7:0]    base_ff, base_in;
   logic [7:0]    next_ff, next_in;
   logic          fin_ff, fin_in;
   logic [7:0]    i_ff, i_in;
   logic [7:0]    ack_ff, ack_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic          pend_valid_ff, pend_valid_in;
   logic [9:0]    pend_ff, pend_in;
   logic          out_valid_ff, out_valid_in;
   logic [9:0]    out_ff, out_in;
   logic          last_ff, last_in;

   logic [8:0]    top, tot_m1, lim;
   logic [3:0]    w_inc;
   logic          age_hit, age_fire;
   logic          emit;
   logic [9:0]    emit_word;
   logic          push;

   always_comb begin
      top     = {1'b0, base_ff} + {5'b0, span_ff};
      tot_m1  = {1'b0, total_ff} - 9'd1;
      lim     = (top < tot_m1) ? top : tot_m1;
      w_inc   = (rd_ff[3:0] == WAIT_MAX) ? WAIT_MAX : rd_ff[3:0] + 4'd1;
      age_hit = (i_ff < next_ff) && !rd_ff[4];
      age_fire = age_hit && (w_inc > tmo_ff);

      stat.clear_end  = (clr_ff == AW'(MAX_PACKETS - 1));
      stat.in_range   = base_ff < total_ff;
      stat.new_ok     = {1'b0, next_ff} <= lim;
      stat.age_end    = {1'b0, i_ff} == lim;
      stat.ack_ok     = (ack_ff >= base_ff) && (ack_ff < next_ff);
      stat.slide_go   = rd_ff[4];
      stat.fin_now    = base_ff >= total_ff;
      stat.finished   = fin_ff;
      stat.push_block = pend_valid_ff && out_valid_ff && !rsp_tready;
   end

   // Memory address and write data.
   always_comb begin
      seq_sel = i_ff;
      if (cmd.ack_rd || cmd.ack_wr) begin
         seq_sel = ack_ff;
      end else if (cmd.slide_rd || cmd.slide_wr) begin
         seq_sel = base_ff;
      end
      mem_addr  = cmd.clear_wr ? clr_ff : slot_tab[seq_sel];
      mem_we    = cmd.clear_wr || (cmd.age_wr && age_hit) || cmd.ack_wr || cmd.slide_wr;
      mem_wdata = '0;
      if (cmd.age_wr) begin
         mem_wdata = {rd_ff[4], age_fire ? 4'd0 : w_inc};
      end else if (cmd.ack_wr) begin
         mem_wdata = {1'b1, rd_ff[3:0]};
      end else if (cmd.slide_wr) begin
         mem_wdata = {1'b0, rd_ff[3:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.age_rd || cmd.ack_rd || cmd.slide_rd) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // Result word: transfer_done, is_resend, send_seq.
   always_comb begin
      emit = cmd.emit_new || (cmd.age_wr && age_fire) || (cmd.done_chk && stat.fin_now);
      if (cmd.emit_new) begin
         emit_word = {2'b00, next_ff};
      end else if (cmd.age_wr) begin
         emit_word = {2'b01, i_ff};
      end else begin
         emit_word = {2'b10, 8'd0};
      end
   end

   always_comb begin
      total_in = total_ff;
      span_in  = span_ff;
      tmo_in   = tmo_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_TOTAL:   total_in = csr_wdata;
            REG_SPAN:    span_in  = csr_wdata[3:0];
            REG_TIMEOUT: tmo_in   = csr_wdata[3:0];
            default:     total_in = total_ff;
         endcase
      end

      base_in = base_ff;
      next_in = next_ff;
      fin_in  = fin_ff;
      i_in    = i_ff;
      ack_in  = ack_ff;
      clr_in  = clr_ff;
      if (cmd.clear_start) begin
         base_in = '0;
         next_in = '0;
         fin_in  = 1'b0;
         clr_in  = '0;
      end
      if (cmd.clear_wr) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.step_start) begin
         ack_in = ack_seq;
      end
      if (cmd.emit_new) begin
         next_in = next_ff + 8'd1;
      end
      if (cmd.age_init) begin
         i_in = base_ff;
      end
      if (cmd.age_wr) begin
         i_in = i_ff + 8'd1;
      end
      if (cmd.slide_wr) begin
         base_in = base_ff + 8'd1;
      end
      if (cmd.done_chk && stat.fin_now) begin
         fin_in = 1'b1;
      end

      // A result waits in the pending slot until the next one shows whether it ends the
      // transaction's burst; the flush marks it last.
      push          = (emit && pend_valid_ff) || (cmd.flush && pend_valid_ff);
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_in       = emit_word;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = (out_valid_ff && !rsp_tready) || push;
      out_in       = push ? pend_ff : out_ff;
      last_in      = push ? cmd.flush : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= TOTAL_RST;
         span_ff       <= SPAN_RST;
         tmo_ff        <= TIMEOUT_RST;
         base_ff       <= '0;
         next_ff       <= '0;
         fin_ff        <= 1'b0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         total_ff      <= total_in;
         span_ff       <= span_in;
         tmo_ff        <= tmo_in;
         base_ff       <= base_in;
         next_ff       <= next_in;
         fin_ff        <= fin_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      ack_ff  <= ack_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/srsw_checker.sv =====
module srsw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A result waiting on the output holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // Completion is always the final result of its step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tlast)
      else $error("completion result not marked last");

   // Completion carries no packet and no resend flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8:0] == 9'd0)
      else $error("completion result carries a packet");

   // The clearing pass after reset keeps the input closed.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("input ready during clearing pass");

endmodule

bind selective_repeat_sender_window_unit srsw_checker u_srsw_checker (.*);

// ===== tb/selective_repeat_sender_window_check.sv =====
module selective_repeat_sender_window_check
   import srsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          base_seen,
   output int          fresh_seen,
   output logic        finished_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] seq;
      logic       resend;
      logic       done;
      logic       last;
   } send_rec_type;

   logic [7:0] total_cfg;
   logic [3:0] span_cfg;
   logic [3:0] limit_cfg;

   bit         acked_slot [256];
   logic [3:0] wait_age [256];
   int         win_base;
   int         next_fresh;
   bit         xfer_done;

   send_rec_type pending_sends [$];
   int           err_total = 0;

   function automatic send_rec_type make_rec(input logic [7:0] seq, input logic resend,
                                             input logic done);
      send_rec_type rec;
      rec = '0;
      rec.seq = seq;
      rec.resend = resend;
      rec.done = done;
      return rec;
   endfunction

   task automatic wipe_transfer();
      foreach (acked_slot[i]) begin
         acked_slot[i] = 1'b0;
         wait_age[i] = '0;
      end
      win_base = 0;
      next_fresh = 0;
      xfer_done = 1'b0;
   endtask

   task automatic log_failure(input string what);
      err_total++;
      if (err_total <= 10) begin
         $display("[%0t] %s", $time, what);
      end
   endtask

   // Works out the packets one input transaction makes the sender emit: the new
   // packet first, then timeout resends in ascending order, then completion.
   task automatic advance_window(input logic [1:0] fn, input logic [7:0] ack_no);
      int           far_edge;
      int           reach;
      send_rec_type batch [$];
      if (fn == FUNC_START) begin
         wipe_transfer();
         return;
      end
      if (xfer_done) begin
         return;
      end
      if (win_base < int'(total_cfg)) begin
         far_edge = win_base + int'(span_cfg);
         reach = (far_edge < int'(total_cfg) - 1) ? far_edge : int'(total_cfg) - 1;
         if (next_fresh <= reach) begin
            batch.push_back(make_rec(8'(next_fresh), 1'b0, 1'b0));
            next_fresh++;
         end
         // Only packets already sent and still unacknowledged age.
         if (fn != FUNC_ACK) begin
            for (int i = win_base; i <= reach; i++) begin
               if (i < next_fresh && !acked_slot[i]) begin
                  if (wait_age[i] != WAIT_MAX) begin
                     wait_age[i] = wait_age[i] + 4'd1;
                  end
                  if (wait_age[i] > limit_cfg) begin
                     batch.push_back(make_rec(8'(i), 1'b1, 1'b0));
                     wait_age[i] = '0;
                  end
               end
            end
         end
      end
      if (fn == FUNC_ACK && int'(ack_no) >= win_base && int'(ack_no) < next_fresh) begin
         acked_slot[ack_no] = 1'b1;
         while (win_base < int'(total_cfg) && acked_slot[win_base]) begin
            acked_slot[win_base] = 1'b0;
            win_base++;
         end
      end
      if (win_base >= int'(total_cfg)) begin
         xfer_done = 1'b1;
         batch.push_back(make_rec(8'd0, 1'b0, 1'b1));
      end
      if (batch.size() != 0) begin
         batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[k]) begin
         pending_sends.push_back(batch[k]);
      end
   endtask

   always @(posedge clock) begin : watch
      send_rec_type got;
      send_rec_type want;
      if (reset) begin
         total_cfg = TOTAL_RST;
         span_cfg = SPAN_RST;
         limit_cfg = TIMEOUT_RST;
         wipe_transfer();
         pending_sends.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TOTAL:   total_cfg = csr_wdata;
               REG_SPAN:    span_cfg = csr_wdata[3:0];
               REG_TIMEOUT: limit_cfg = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_window(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.seq = rsp_tdata[7:0];
            got.resend = rsp_tdata[8];
            got.done = rsp_tdata[9];
            got.last = rsp_tlast;
            if (pending_sends.size() == 0) begin
               log_failure($sformatf("unexpected transaction: seq %0d resend %b done %b last %b",
                                     got.seq, got.resend, got.done, got.last));
            end else begin
               want = pending_sends.pop_front();
               if (got.seq !== want.seq || got.resend !== want.resend ||
                   got.done !== want.done || got.last !== want.last) begin
                  log_failure($sformatf({"mismatch: expected seq %0d resend %b done %b last %b,",
                                         " got seq %0d resend %b done %b last %b"},
                                        want.seq, want.resend, want.done, want.last,
                                        got.seq, got.resend, got.done, got.last));
               end
            end
         end
      end
      fail_count <= err_total;
      pending <= pending_sends.size();
      base_seen <= win_base;
      fresh_seen <= next_fresh;
      finished_seen <= xfer_done;
   end

endmodule

// ===== tb/selective_repeat_sender_window_unit_test.sv =====
module selective_repeat_sender_window_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import srsw_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 70;
   localparam int PHASE_ITEMS   = 40;

   // The block treats the unused kind as a plain step.
   localparam logic [1:0] FUNC_ODD = FUNC_STEP | FUNC_ACK;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_SLOW
   } rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        hold_go;

   int          fail_count;
   int          pending;
   int          base_seen;
   int          fresh_seen;
   logic        finished_seen;
   int unsigned cycle_count = 0;
   int          burst_left = 0;

   selective_repeat_sender_window_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   selective_repeat_sender_window_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .base_seen     (base_seen),
      .fresh_seen    (fresh_seen),
      .finished_seen (finished_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** selective_repeat_sender_window_unit: FAILED **");
      $finish;
   end

   // The receiver switches between always ready, coin flips and mostly stalled.
   // Once asked, it holds off for a long stretch so the block backs up.
   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      bit          hold_done;
      rsp_tready <= 1'b0;
      mode = RX_STEADY;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               default:   rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offers one transaction, opening a new burst after a random gap when the
   // current one runs out.
   task automatic offer(input logic [1:0] fn, input logic [7:0] ack_no);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= ack_no;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [7:0] tot, input logic [3:0] span,
                             input logic [3:0] tmo);
      write_reg(REG_TOTAL, tot);
      write_reg(REG_SPAN, {4'd0, span});
      write_reg(REG_TIMEOUT, {4'd0, tmo});
      csr_valid <= 1'b0;
   endtask

   // Waits for every predicted packet, then gives the block time to finish a
   // clearing pass or a slide that produces nothing.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int         roll;
      int         ack_pct;
      int         phase_items;
      int         random_items;
      bit         first_phase;
      logic [1:0] fn;
      logic [7:0] ack_no;
      logic [7:0] tot;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= FUNC_START;
      csr_valid <= 1'b0;
      csr_index <= REG_TOTAL;
      csr_wdata <= '0;
      hold_go <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one packet, so the block works on its reset state.
      offer(FUNC_STEP, 8'h00);
      offer(FUNC_ODD, 8'hA5);
      offer(FUNC_ACK, 8'hFF);
      offer(FUNC_ACK, 8'h00);
      offer(FUNC_STEP, 8'h5A);
      offer(FUNC_START, 8'h00);
      settle();

      // An empty transfer completes on its first step.
      set_config(8'd0, 4'd0, 4'd0);
      offer(FUNC_STEP, 8'h00);
      offer(FUNC_START, 8'hFF);
      settle();

      // One-packet window with resends on every aging step, plus stray
      // acknowledgements below the base and beyond anything sent.
      set_config(8'd6, 4'd0, 4'd0);
      offer(FUNC_START, 8'h00);
      offer(FUNC_STEP, 8'h00);
      offer(FUNC_STEP, 8'h00);
      offer(FUNC_ACK, 8'h00);
      offer(FUNC_ACK, 8'h00);
      offer(FUNC_ACK, 8'h05);
      offer(FUNC_ACK, 8'h01);
      settle();

      // Shrinking the total below the base finishes the transfer.
      set_config(8'd1, 4'd0, 4'd0);
      offer(FUNC_STEP, 8'h00);
      offer(FUNC_START, 8'h00);
      settle();

      // Widest window with a saturating counter that never times out.
      set_config(8'd255, 4'd15, 4'd15);
      offer(FUNC_START, 8'h00);
      repeat (4) offer(FUNC_STEP, 8'h00);
      offer(FUNC_ACK, 8'h02);
      offer(FUNC_ACK, 8'h00);
      offer(FUNC_ODD, 8'h00);

      random_items = 0;
      first_phase = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         if (first_phase) begin
            // Few acknowledgements and instant timeouts flood the result side
            // while the receiver holds off.
            set_config(8'd40, 4'd15, 4'd0);
            ack_pct = 15;
            hold_go <= 1'b1;
         end else begin
            tot = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(25, 255))
                                              : 8'($urandom_range(1, 24));
            set_config(tot, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            ack_pct = 30 + 27 * $urandom_range(0, 2);
         end
         first_phase = 1'b0;
         offer(FUNC_START, 8'($urandom_range(0, 255)));
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && !(phase_items > 0 && finished_seen)) begin
            roll = $urandom_range(0, 99);
            ack_no = 8'($urandom_range(0, 255));
            if (roll < 2) begin
               fn = FUNC_START;
            end else if (roll < 2 + ack_pct && fresh_seen > base_seen) begin
               fn = FUNC_ACK;
               ack_no = 8'($urandom_range(base_seen, fresh_seen - 1));
            end else if (roll < 10 + ack_pct) begin
               fn = FUNC_ACK;
            end else if (roll < 15 + ack_pct) begin
               fn = FUNC_ODD;
            end else begin
               fn = FUNC_STEP;
            end
            offer(fn, ack_no);
            phase_items++;
            random_items++;
         end
         // Usually lands after completion and is ignored.
         offer(FUNC_STEP, 8'($urandom_range(0, 255)));
      end

      settle();
      if (fail_count == 0) begin
         $display("** selective_repeat_sender_window_unit: PASSED **");
      end else begin
         $display("** selective_repeat_sender_window_unit: FAILED **");
      end
      $finish;
   end

endmodule
